// ----- src/spm_pkg.sv -----
// Shared types and constants for the stereo peak meter with level trigger.
package spm_pkg;

  localparam int unsigned DefHistoryDepth   = 64;
  localparam int unsigned DefMaxBlockFrames = 4096;

  localparam int unsigned SampleW = 16;
  localparam int unsigned PeakW   = 16;

  localparam int unsigned FpbW     = 13;
  localparam int unsigned HistLenW = 7;
  localparam int unsigned TrigW    = 15;
  localparam int unsigned CfgDataW = 15;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [CfgIdxW-1:0] CfgFramesPerBlock = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHistoryLen     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTriggerLevel   = 2'd2;

  localparam logic [FpbW-1:0]     RstFramesPerBlock = 13'd2048;
  localparam logic [HistLenW-1:0] RstHistoryLen     = 7'd32;
  localparam logic [TrigW-1:0]    RstTriggerLevel   = 15'd0;

  typedef struct packed {
    logic signed [SampleW-1:0] left_sample;
    logic signed [SampleW-1:0] right_sample;
  } in_t;

  typedef struct packed {
    logic [PeakW-1:0] block_peak_left;
    logic [PeakW-1:0] block_peak_right;
    logic [PeakW-1:0] hold_peak_left;
    logic [PeakW-1:0] hold_peak_right;
    logic             recording;
    logic             record_started;
    logic             record_stopped;
  } out_t;

  // Per-lane control from the sequencer.
  typedef struct packed {
    logic take;      // frame beat accepted
    logic last;      // that frame closes the block
    logic rd_en;     // issue one history read
    logic scan_clr;  // restart the hold maximum
  } lane_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

  function automatic logic [PeakW-1:0] magnitude(input logic signed [SampleW-1:0] s);
    logic [PeakW-1:0] u;
    u = PeakW'(s);
    return s[SampleW-1] ? (~u + PeakW'(1)) : u;
  endfunction

endpackage

// ----- src/spm_lane.sv -----
// One channel lane: running block peak, block-peak history and hold-maximum scan.
module spm_lane #(
  parameter int unsigned HISTORY_DEPTH = spm_pkg::DefHistoryDepth,
  localparam int unsigned AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  spm_pkg::lane_ctl_t                ctl_i,
  input  logic signed [spm_pkg::SampleW-1:0] sample_i,
  input  logic [AW-1:0]                     wr_addr_i,
  input  logic [AW-1:0]                     rd_addr_i,
  output logic [spm_pkg::PeakW-1:0]         block_peak_o,
  output logic [spm_pkg::PeakW-1:0]         hold_peak_o
);
  import spm_pkg::*;

  logic [PeakW-1:0] mag;
  logic [PeakW-1:0] peak_now;
  logic [PeakW-1:0] running_q;
  logic [PeakW-1:0] block_peak_q;
  logic [PeakW-1:0] hold_q;
  logic [PeakW-1:0] hist_mem [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] hist_vld_q;
  logic [PeakW-1:0] rd_data_q;
  logic             rd_hit_q;
  logic             rd_vld_q;

  assign mag      = magnitude(sample_i);
  assign peak_now = (mag > running_q) ? mag : running_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q  <= '0;
      hist_vld_q <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      rd_vld_q <= ctl_i.rd_en;
      if (ctl_i.take) begin
        if (ctl_i.last) begin
          running_q             <= '0;
          hist_vld_q[wr_addr_i] <= 1'b1;
        end else begin
          running_q <= peak_now;
        end
      end
    end
  end

  // History store; entries never written read as zero through the valid bits.
  always_ff @(posedge clk_i) begin
    if (ctl_i.take && ctl_i.last) begin
      hist_mem[wr_addr_i] <= peak_now;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= hist_mem[rd_addr_i];
      rd_hit_q  <= hist_vld_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.take && ctl_i.last) begin
      block_peak_q <= peak_now;
    end
    if (ctl_i.scan_clr) begin
      hold_q <= '0;
    end else if (rd_vld_q && rd_hit_q && (rd_data_q > hold_q)) begin
      hold_q <= rd_data_q;
    end
  end

  assign block_peak_o = block_peak_q;
  assign hold_peak_o  = hold_q;

endmodule

// ----- src/spm_merge.sv -----
// Merge stage: record-flag decision from both lanes and the result register.
module spm_merge (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  logic [spm_pkg::PeakW-1:0]  block_peak_left_i,
  input  logic [spm_pkg::PeakW-1:0]  block_peak_right_i,
  input  logic [spm_pkg::PeakW-1:0]  hold_peak_left_i,
  input  logic [spm_pkg::PeakW-1:0]  hold_peak_right_i,
  input  logic [spm_pkg::TrigW-1:0]  trigger_level_i,
  output logic                       slot_free_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output spm_pkg::out_t              out_data_o
);
  import spm_pkg::*;

  logic             record_flag_q;
  logic             record_flag_d;
  logic             set_flag;
  logic [PeakW-1:0] trig;
  logic             out_valid_q;
  out_t             out_q;

  assign trig = PeakW'(trigger_level_i);

  always_comb begin
    set_flag = record_flag_q;
    if (!set_flag && ((block_peak_left_i > trig) || (block_peak_right_i > trig))) begin
      set_flag = 1'b1;
    end
    record_flag_d = set_flag;
    if (set_flag && (hold_peak_left_i < trig) && (hold_peak_right_i < trig)) begin
      record_flag_d = 1'b0;
    end
    if (trigger_level_i == '0) begin
      record_flag_d = 1'b1;
    end
  end

  assign slot_free_o = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      record_flag_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (load_i) begin
        record_flag_q <= record_flag_d;
        out_valid_q   <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      out_q.block_peak_left  <= block_peak_left_i;
      out_q.block_peak_right <= block_peak_right_i;
      out_q.hold_peak_left   <= hold_peak_left_i;
      out_q.hold_peak_right  <= hold_peak_right_i;
      out_q.recording        <= record_flag_d;
      out_q.record_started   <= !record_flag_q && record_flag_d;
      out_q.record_stopped   <= record_flag_q && !record_flag_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- src/stereo_peak_meter_level_trigger_core.sv -----
// Top level: config registers, frame/ring sequencing, two channel lanes and the merge.
//
// Input channel in_valid_i/in_stall_o carries one stereo frame per beat.
// Output channel out_valid_o/out_stall_i carries one result per finished block.
// Frames inside a block are taken one per cycle and produce no result.
// The frame that closes a block writes both block peaks to the history and
// starts a scan of the hold window: one history read per cycle in each lane
// over history_len entries (history_len after clamping to 1..HISTORY_DEPTH),
// with the input stalled; the result is registered when the scan ends.
// The result sits in an output register; frames of the next block are taken
// while it waits. If a result is still stalled when the next block's scan
// ends, the block holds input stalled until that result leaves.
// Configuration writes on cfg_we_i/cfg_idx_i/cfg_data_i take effect at once;
// they are to be made only while the block is idle, which it does not enforce.
// Reset clears the running peaks, the frame count, the ring index, the record
// flag and the history valid bits; the history then reads as all zero with no
// clearing pass, and the output register is empty.
module stereo_peak_meter_level_trigger_core #(
  parameter int unsigned HISTORY_DEPTH    = spm_pkg::DefHistoryDepth,
  parameter int unsigned MAX_BLOCK_FRAMES = spm_pkg::DefMaxBlockFrames
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [spm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [spm_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  spm_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output spm_pkg::out_t                 out_data_o
);
  import spm_pkg::*;

  localparam int unsigned AW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned HLW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned FCW = (MAX_BLOCK_FRAMES > 1) ? $clog2(MAX_BLOCK_FRAMES) : 1;
  localparam int unsigned BLW = $clog2(MAX_BLOCK_FRAMES + 1);

  logic [FpbW-1:0]     frames_per_block_q;
  logic [HistLenW-1:0] history_len_q;
  logic [TrigW-1:0]    trigger_level_q;

  state_e         state_q, state_d;
  logic [FCW-1:0] frame_cnt_q, frame_cnt_d;
  logic [AW-1:0]  ring_q, ring_d;
  logic [HLW-1:0] scan_cnt_q, scan_cnt_d;

  logic [BLW-1:0] blen;
  logic [HLW-1:0] hlen;
  logic [BLW-1:0] frame_next;
  logic [HLW-1:0] wr_sel;
  logic [HLW-1:0] wr_inc;
  logic [AW-1:0]  wr_addr;
  logic [AW-1:0]  rd_addr;
  logic           take;
  logic           last;
  logic           load;
  logic           slot_free;
  lane_ctl_t      lane_ctl;

  logic [PeakW-1:0] bpk_l, bpk_r, hpk_l, hpk_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_per_block_q <= RstFramesPerBlock;
      history_len_q      <= RstHistoryLen;
      trigger_level_q    <= RstTriggerLevel;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgFramesPerBlock: frames_per_block_q <= cfg_data_i[FpbW-1:0];
        CfgHistoryLen:     history_len_q      <= cfg_data_i[HistLenW-1:0];
        CfgTriggerLevel:   trigger_level_q    <= cfg_data_i[TrigW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp block and window lengths to their legal ranges.
  always_comb begin
    if (frames_per_block_q == '0) begin
      blen = BLW'(1);
    end else if (32'(frames_per_block_q) > 32'(MAX_BLOCK_FRAMES)) begin
      blen = BLW'(MAX_BLOCK_FRAMES);
    end else begin
      blen = BLW'(frames_per_block_q);
    end
    if (history_len_q == '0) begin
      hlen = HLW'(1);
    end else if (32'(history_len_q) > 32'(HISTORY_DEPTH)) begin
      hlen = HLW'(HISTORY_DEPTH);
    end else begin
      hlen = HLW'(history_len_q);
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign take       = in_valid_i && !in_stall_o;
  assign frame_next = BLW'(frame_cnt_q) + BLW'(1);
  assign last       = !(frame_next < blen);

  // Wrap a stale ring index before the write, then advance.
  assign wr_sel  = (HLW'(ring_q) >= hlen) ? '0 : HLW'(ring_q);
  assign wr_addr = wr_sel[AW-1:0];
  assign wr_inc  = wr_sel + HLW'(1);
  assign rd_addr = scan_cnt_q[AW-1:0];

  always_comb begin
    state_d     = state_q;
    frame_cnt_d = frame_cnt_q;
    ring_d      = ring_q;
    scan_cnt_d  = scan_cnt_q;
    load        = 1'b0;
    lane_ctl    = '0;
    lane_ctl.take = take;
    lane_ctl.last = last;
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          if (last) begin
            frame_cnt_d       = '0;
            ring_d            = (wr_inc >= hlen) ? '0 : wr_inc[AW-1:0];
            scan_cnt_d        = '0;
            lane_ctl.scan_clr = 1'b1;
            state_d           = ST_SCAN;
          end else begin
            frame_cnt_d = frame_next[FCW-1:0];
          end
        end
      end
      ST_SCAN: begin
        if (scan_cnt_q < hlen) begin
          lane_ctl.rd_en = 1'b1;
          scan_cnt_d     = scan_cnt_q + HLW'(1);
        end else begin
          // last read data folds into the hold maximum this cycle
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      frame_cnt_q <= '0;
      ring_q      <= '0;
      scan_cnt_q  <= '0;
    end else begin
      state_q     <= state_d;
      frame_cnt_q <= frame_cnt_d;
      ring_q      <= ring_d;
      scan_cnt_q  <= scan_cnt_d;
    end
  end

  spm_lane #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_lane_left (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (lane_ctl),
    .sample_i     (in_data_i.left_sample),
    .wr_addr_i    (wr_addr),
    .rd_addr_i    (rd_addr),
    .block_peak_o (bpk_l),
    .hold_peak_o  (hpk_l)
  );

  spm_lane #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_lane_right (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (lane_ctl),
    .sample_i     (in_data_i.right_sample),
    .wr_addr_i    (wr_addr),
    .rd_addr_i    (rd_addr),
    .block_peak_o (bpk_r),
    .hold_peak_o  (hpk_r)
  );

  spm_merge u_merge (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .load_i             (load),
    .block_peak_left_i  (bpk_l),
    .block_peak_right_i (bpk_r),
    .hold_peak_left_i   (hpk_l),
    .hold_peak_right_i  (hpk_r),
    .trigger_level_i    (trigger_level_q),
    .slot_free_o        (slot_free),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_data_o         (out_data_o)
  );

endmodule

// ----- tb/stereo_peak_meter_level_trigger_core_checker.sv -----
// Checker for the stereo peak meter: tracks config, predicts block results, compares beats.
`timescale 1ns / 1ps

module stereo_peak_meter_level_trigger_core_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [spm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [spm_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  spm_pkg::in_t                 in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  spm_pkg::out_t                out_data_i,
  output int unsigned                  errors_o,
  output int unsigned                  pending_o
);
  import spm_pkg::*;

  localparam int unsigned HistDepth = DefHistoryDepth;
  localparam int unsigned MaxFrames = DefMaxBlockFrames;

  logic [FpbW-1:0]     blk_len_reg;
  logic [HistLenW-1:0] hist_len_reg;
  logic [TrigW-1:0]    trig_reg;

  logic [PeakW-1:0] run_peak_l, run_peak_r;
  logic [PeakW-1:0] hist_l [HistDepth];
  logic [PeakW-1:0] hist_r [HistDepth];
  int unsigned      frames_taken;
  int unsigned      ring_pos;
  logic             rec_flag;

  out_t block_reports_q[$];

  function automatic logic [PeakW-1:0] sample_mag(logic signed [SampleW-1:0] s);
    int v;
    v = s;
    return PeakW'(v < 0 ? -v : v);
  endfunction

  task automatic clear_meter();
    blk_len_reg  = RstFramesPerBlock;
    hist_len_reg = RstHistoryLen;
    trig_reg     = RstTriggerLevel;
    run_peak_l   = '0;
    run_peak_r   = '0;
    frames_taken = 0;
    ring_pos     = 0;
    rec_flag     = 1'b0;
    for (int i = 0; i < HistDepth; i++) begin
      hist_l[i] = '0;
      hist_r[i] = '0;
    end
    block_reports_q.delete();
  endtask

  task automatic take_frame(in_t f);
    int unsigned      blen, hlen;
    logic [PeakW-1:0] mag_l, mag_r, bl, br, hl, hr;
    logic             was_rec;
    out_t             r;
    mag_l = sample_mag(f.left_sample);
    mag_r = sample_mag(f.right_sample);
    if (mag_l > run_peak_l) run_peak_l = mag_l;
    if (mag_r > run_peak_r) run_peak_r = mag_r;

    blen = (blk_len_reg == 0) ? 1 : (blk_len_reg > MaxFrames) ? MaxFrames : blk_len_reg;
    if (frames_taken + 1 < blen) begin
      frames_taken++;
      return;
    end
    frames_taken = 0;
    bl = run_peak_l;
    br = run_peak_r;
    run_peak_l = '0;
    run_peak_r = '0;

    // Wrap a stale ring position before the write (history length may have shrunk).
    hlen = (hist_len_reg == 0) ? 1 : (hist_len_reg > HistDepth) ? HistDepth : hist_len_reg;
    if (ring_pos >= hlen) ring_pos = 0;
    hist_l[ring_pos] = bl;
    hist_r[ring_pos] = br;
    ring_pos++;
    if (ring_pos >= hlen) ring_pos = 0;

    hl = '0;
    hr = '0;
    for (int i = 0; i < hlen; i++) begin
      if (hist_l[i] > hl) hl = hist_l[i];
      if (hist_r[i] > hr) hr = hist_r[i];
    end

    was_rec = rec_flag;
    if (trig_reg == 0) begin
      rec_flag = 1'b1;
    end else begin
      if (!rec_flag && (bl > trig_reg || br > trig_reg)) rec_flag = 1'b1;
      if (rec_flag && hl < trig_reg && hr < trig_reg) rec_flag = 1'b0;
    end

    r.block_peak_left  = bl;
    r.block_peak_right = br;
    r.hold_peak_left   = hl;
    r.hold_peak_right  = hr;
    r.recording        = rec_flag;
    r.record_started   = !was_rec && rec_flag;
    r.record_stopped   = was_rec && !rec_flag;
    block_reports_q.push_back(r);
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t peak meter check: %s got %0d want %0d", $time, what, got, want);
    errors_o++;
  endtask

  task automatic check_report(out_t got);
    out_t want;
    if (block_reports_q.size() == 0) begin
      report_mismatch("result beat with nothing pending, count", 1, 0);
      return;
    end
    want = block_reports_q.pop_front();
    if (got.block_peak_left !== want.block_peak_left)
      report_mismatch("block_peak_left", got.block_peak_left, want.block_peak_left);
    if (got.block_peak_right !== want.block_peak_right)
      report_mismatch("block_peak_right", got.block_peak_right, want.block_peak_right);
    if (got.hold_peak_left !== want.hold_peak_left)
      report_mismatch("hold_peak_left", got.hold_peak_left, want.hold_peak_left);
    if (got.hold_peak_right !== want.hold_peak_right)
      report_mismatch("hold_peak_right", got.hold_peak_right, want.hold_peak_right);
    if (got.recording !== want.recording)
      report_mismatch("recording", got.recording, want.recording);
    if (got.record_started !== want.record_started)
      report_mismatch("record_started", got.record_started, want.record_started);
    if (got.record_stopped !== want.record_stopped)
      report_mismatch("record_stopped", got.record_stopped, want.record_stopped);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_meter();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgFramesPerBlock: blk_len_reg = cfg_data_i[FpbW-1:0];
          CfgHistoryLen:     hist_len_reg = cfg_data_i[HistLenW-1:0];
          CfgTriggerLevel:   trig_reg = cfg_data_i[TrigW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) take_frame(in_data_i);
      if (out_valid_i && !out_stall_i) check_report(out_data_i);
    end
    pending_o = block_reports_q.size();
  end

endmodule

// ----- tb/stereo_peak_meter_level_trigger_core_tb.sv -----
// Testbench top: clock, reset, frame and config stimulus, output stall pattern and verdict.
`timescale 1ns / 1ps

module stereo_peak_meter_level_trigger_core_tb;
  import spm_pkg::*;

  localparam int unsigned RxFree  = 0;
  localparam int unsigned RxHeld  = 1;
  localparam int unsigned RxNoisy = 2;

  localparam int unsigned DrainCycles  = 100;
  localparam int unsigned RandomFrames = 1200;

  logic                clk_i;
  logic                rst_ni    = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_t                 in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_t                out_data;

  int unsigned errors, pending;
  int unsigned burst_left = 1;
  int unsigned amp_l, amp_r;
  int unsigned rx_mode = RxFree;
  int unsigned rx_left = 0;

  stereo_peak_meter_level_trigger_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  stereo_peak_meter_level_trigger_core_checker peak_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Result side: free runs, held stretches and noisy stretches.
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          rx_mode = RxFree;
          rx_left = $urandom_range(20, 120);
        end
        1: begin
          rx_mode = RxHeld;
          rx_left = $urandom_range(1, 40);
        end
        default: begin
          rx_mode = RxNoisy;
          rx_left = $urandom_range(10, 60);
        end
      endcase
    end
    rx_left--;
    case (rx_mode)
      RxHeld:  out_stall <= 1'b1;
      RxNoisy: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= 1'b0;
    endcase
  end

  function automatic in_t stereo(int l, int r);
    in_t f;
    f.left_sample  = SampleW'(l);
    f.right_sample = SampleW'(r);
    return f;
  endfunction

  function automatic logic signed [SampleW-1:0] make_sample(int unsigned amp);
    int          v;
    int unsigned m;
    logic        neg;
    if ($urandom_range(0, 15) == 0) begin
      case ($urandom_range(0, 3))
        0: v = -32768;
        1: v = 32767;
        2: v = 0;
        default: v = -1;
      endcase
    end else begin
      m   = $urandom_range(0, amp);
      neg = ($urandom_range(0, 1) == 1);
      if (!neg && m > 32767) m = 32767;
      v = neg ? -int'(m) : int'(m);
    end
    return SampleW'(v);
  endfunction

  // Pick a block envelope that lands below, around or above the trigger.
  function automatic int unsigned pick_amp(int unsigned trig);
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 15);
      1: return (trig == 0) ? $urandom_range(0, 32768) : $urandom_range(0, trig);
      2: return $urandom_range(trig, 32768);
      3: return 32768;
      default: return $urandom_range(0, 32768);
    endcase
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CfgDataW'(val);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic program_meter(int unsigned fpb, int unsigned hlen, int unsigned trig);
    write_reg(CfgFramesPerBlock, fpb);
    write_reg(CfgHistoryLen, hlen);
    write_reg(CfgTriggerLevel, trig);
  endtask

  // Wait until every block result is out, then let a history walk finish.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic send_frame(in_t f);
    int unsigned gap;
    in_valid <= 1'b1;
    in_data  <= f;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  task automatic send_noise(int unsigned n, int unsigned blen, int unsigned trig);
    in_t f;
    for (int unsigned k = 0; k < n; k++) begin
      if (k % blen == 0) begin
        amp_l = pick_amp(trig);
        amp_r = pick_amp(trig);
      end
      f.left_sample  = make_sample(amp_l);
      f.right_sample = make_sample(amp_r);
      send_frame(f);
    end
  endtask

  initial begin
    int unsigned sent, fpb, hlen, trig, blen, n;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Partial block under the reset config: sample extremes, no result yet.
    send_frame(stereo(32767, -32768));
    send_frame(stereo(-32768, 32767));
    send_frame(stereo(0, 0));
    send_frame(stereo(-1, 1));
    send_frame(stereo(1, -1));
    send_frame(stereo(16'h5555, 16'hAAAA));
    settle();

    // Shrink the block below the frames taken: the next frame closes it.
    write_reg(CfgHistoryLen, 1);
    write_reg(CfgTriggerLevel, 32767);
    write_reg(CfgFramesPerBlock, 1);
    send_frame(stereo(0, 0));
    send_frame(stereo(0, 0));
    send_frame(stereo(-32768, 0));
    send_frame(stereo(32767, 32767));
    send_frame(stereo(0, 0));
    settle();

    // Zero trigger: always recording.
    write_reg(CfgTriggerLevel, 0);
    send_frame(stereo(0, 0));
    send_frame(stereo(5, -5));
    settle();

    // Zero block and history lengths act as one; trigger at its lowest.
    program_meter(0, 0, 1);
    send_frame(stereo(1, 0));
    send_frame(stereo(0, 0));
    send_frame(stereo(2, -2));
    send_frame(stereo(0, -32768));
    settle();

    sent = 0;
    while (sent < RandomFrames) begin
      case ($urandom_range(0, 7))
        0: fpb = 0;
        1, 6: fpb = 1;
        2: fpb = 2;
        3: fpb = 3;
        4: fpb = $urandom_range(4, 12);
        5: fpb = $urandom_range(13, 40);
        default: fpb = $urandom_range(2, 6);
      endcase
      case ($urandom_range(0, 6))
        0: hlen = 0;
        1: hlen = 1;
        2: hlen = 64;
        3: hlen = 127;
        4: hlen = $urandom_range(21, 63);
        default: hlen = $urandom_range(2, 20);
      endcase
      case ($urandom_range(0, 5))
        0: trig = 0;
        1: trig = 32767;
        2: trig = $urandom_range(1, 32767);
        3: trig = $urandom_range(1, 2000);
        default: trig = $urandom_range(100, 20000);
      endcase
      program_meter(fpb, hlen, trig);
      blen = (fpb == 0) ? 1 : fpb;
      n = $urandom_range(20, 160);
      send_noise(n, blen, trig);
      sent += n;
      settle();
    end

    // Block length past the maximum: a long partial block, then shrink so the next frame
    // closes it.
    program_meter(8191, 127, 20000);
    send_noise(40, 4096, 20000);
    settle();
    write_reg(CfgFramesPerBlock, 1);
    send_frame(stereo(0, 0));
    settle();

    if (errors == 0) begin
      $display("stereo_peak_meter_level_trigger_core_tb: done, clean");
    end else begin
      $display("stereo_peak_meter_level_trigger_core_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("stereo_peak_meter_level_trigger_core_tb: done, errors");
    $finish;
  end

endmodule
